// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the keystream generator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define PRF_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// When cond holds, sig keeps its value at the next edge.
`define PRF_ASSERT_HOLD(lbl, clk, rstn, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

// ===== rtl/prf_pkg.sv =====
// ----------------------------------------------------------------------------
// prf_pkg
// Types, codes and AES-256 helper functions for the CTR keystream generator.
// ----------------------------------------------------------------------------
package prf_pkg;

	localparam int BLOCK_BYTES       = 16;
	localparam int MAX_REQ_BYTES_DEF = 960;
	localparam int CMD_DEPTH_DEF     = 2;
	localparam int LEN_W             = 10;
	localparam int CNT_W             = 5;
	localparam int ADDR_W            = 6;

	localparam logic OP_GENERATE = 1'b0;
	localparam logic OP_RESTART  = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_NO_BUDGET = 2'd2;

	localparam logic [2:0] REG_KEY0    = 3'd0;
	localparam logic [2:0] REG_KEY1    = 3'd1;
	localparam logic [2:0] REG_KEY2    = 3'd2;
	localparam logic [2:0] REG_KEY3    = 3'd3;
	localparam logic [2:0] REG_MAX_INV = 3'd4;

	typedef enum logic {CMD_GENERATE, CMD_RESTART} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [LEN_W-1:0] len;
	} cmd_t;

	typedef struct packed {
		logic expand;
		logic encrypt;
	} aes_req_t;

	typedef struct packed {
		logic done;
	} aes_resp_t;

	typedef struct packed {
		logic [127:0]     data;
		logic [CNT_W-1:0] cnt;
		logic             last;
		logic [1:0]       status;
	} res_t;

	localparam logic [2047:0] SBOX_BITS = {
		128'h637c777bf26b6fc53001672bfed7ab76,
		128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115,
		128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84,
		128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8,
		128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973,
		128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479,
		128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
		128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df,
		128'h8ca1890dbfe6426841992d0fb054bb16
	};

	function automatic logic [7:0] sbox(input logic [7:0] b);
		logic [10:0] pos;
		pos = 11'd2047 - {b, 3'b000};
		return SBOX_BITS[pos -: 8];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	function automatic logic [7:0] rcon(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd1:    r = 8'h01;
			3'd2:    r = 8'h02;
			3'd3:    r = 8'h04;
			3'd4:    r = 8'h08;
			3'd5:    r = 8'h10;
			3'd6:    r = 8'h20;
			3'd7:    r = 8'h40;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Next 128-bit group of the AES-256 schedule from the two groups before it.
	function automatic logic [127:0] key_step(input logic [127:0] prev2,
	                                          input logic [127:0] prev1,
	                                          input logic [3:0]   g);
		logic [31:0] t;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;
		t = prev1[127:96];
		if (!g[0]) begin
			t = sub_word({t[7:0], t[31:8]});
			t[7:0] = t[7:0] ^ rcon(g[3:1]);
		end else begin
			t = sub_word(t);
		end
		w0 = prev2[31:0] ^ t;
		w1 = prev2[63:32] ^ w0;
		w2 = prev2[95:64] ^ w1;
		w3 = prev2[127:96] ^ w2;
		return {w3, w2, w1, w0};
	endfunction

	function automatic logic [127:0] aes_round(input logic [127:0] s_in,
	                                           input logic [127:0] rk,
	                                           input logic         last_rnd);
		logic [7:0]   s [16];
		logic [7:0]   t [16];
		logic [7:0]   a0;
		logic [7:0]   a1;
		logic [7:0]   a2;
		logic [7:0]   a3;
		logic [7:0]   all;
		logic [127:0] o;
		for (int i = 0; i < 16; i++) s[i] = sbox(s_in[8*i +: 8]);
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++) t[c*4+i] = s[((c+i) & 3)*4+i];
		if (!last_rnd) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[c*4];
				a1 = t[c*4+1];
				a2 = t[c*4+2];
				a3 = t[c*4+3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[c*4]   = a0 ^ all ^ xtime(a0 ^ a1);
				t[c*4+1] = a1 ^ all ^ xtime(a1 ^ a2);
				t[c*4+2] = a2 ^ all ^ xtime(a2 ^ a3);
				t[c*4+3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) o[8*i +: 8] = t[i] ^ rk[8*i +: 8];
		return o;
	endfunction

	// Zero every byte at or above cnt.
	function automatic logic [127:0] byte_mask(input logic [127:0] d,
	                                           input logic [CNT_W-1:0] cnt);
		logic [127:0] m;
		m = '0;
		for (int i = 0; i < 16; i++)
			if (CNT_W'(i) < cnt) m[8*i +: 8] = d[8*i +: 8];
		return m;
	endfunction

endpackage

// ===== rtl/prf_front.sv =====
// ----------------------------------------------------------------------------
// prf_front
// Accepts requests, decodes the opcode and clamps the length into a command.
// ----------------------------------------------------------------------------
module prf_front #(
	parameter int MAX_REQUEST_BYTES = prf_pkg::MAX_REQ_BYTES_DEF
) (
	input  logic                       push,
	input  logic                       opcode,
	input  logic [prf_pkg::LEN_W-1:0]  byte_length,
	output logic                       full,
	input  logic                       q_full,
	output logic                       q_wr,
	output prf_pkg::cmd_t              q_cmd
);

	localparam logic [prf_pkg::LEN_W-1:0] MAX_LEN = prf_pkg::LEN_W'(MAX_REQUEST_BYTES);

	assign full = q_full;
	assign q_wr = push && !q_full;

	always_comb begin
		q_cmd.kind = (opcode == prf_pkg::OP_RESTART) ? prf_pkg::CMD_RESTART
		                                             : prf_pkg::CMD_GENERATE;
		q_cmd.len  = (byte_length > MAX_LEN) ? MAX_LEN : byte_length;
	end

endmodule

// ===== rtl/prf_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// prf_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module prf_cmd_fifo #(
	parameter int DEPTH = prf_pkg::CMD_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  prf_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd,
	output prf_pkg::cmd_t rd_cmd,
	output logic          valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	prf_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign valid  = (cnt_q != '0);
	assign rd_cmd = mem_q[rptr_q];
	assign do_wr  = wr && !full;
	assign do_rd  = rd && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == PTR_W'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			if (do_rd) rptr_q <= (rptr_q == PTR_W'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wr_cmd;
	end

endmodule

// ===== rtl/prf_aes_core.sv =====
// ----------------------------------------------------------------------------
// prf_aes_core
// Iterative AES-256: key schedule one group a cycle, one round a cycle.
// ----------------------------------------------------------------------------
module prf_aes_core (
	input  logic               clk,
	input  logic               arst_n,
	input  prf_pkg::aes_req_t  req,
	input  logic [255:0]       key,
	input  logic [63:0]        ctr,
	output prf_pkg::aes_resp_t resp,
	output logic [127:0]       data
);

	typedef enum logic [1:0] {C_IDLE, C_EXP, C_ENC} cstate_t;

	localparam logic [3:0] LAST_STEP = 4'd14;

	cstate_t      state_q;
	logic [3:0]   step_q;
	logic         done_q;
	logic [127:0] st_q;
	logic [127:0] prev2_q;
	logic [127:0] prev1_q;
	logic [127:0] rk_q [15];
	logic [127:0] next_grp;

	assign next_grp  = prf_pkg::key_step(prev2_q, prev1_q, step_q);
	assign resp.done = done_q;
	assign data      = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
			st_q    <= '0;
			prev2_q <= '0;
			prev1_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (req.expand) begin
						prev2_q <= key[127:0];
						prev1_q <= key[255:128];
						step_q  <= 4'd2;
						state_q <= C_EXP;
					end else if (req.encrypt) begin
						st_q    <= {64'd0, ctr} ^ rk_q[0];
						step_q  <= 4'd1;
						state_q <= C_ENC;
					end
				end
				C_EXP: begin
					prev2_q <= prev1_q;
					prev1_q <= next_grp;
					step_q  <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				C_ENC: begin
					st_q   <= prf_pkg::aes_round(st_q, rk_q[step_q], step_q == LAST_STEP);
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// Round-key store: written by the schedule only.
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && req.expand) begin
			rk_q[0] <= key[127:0];
			rk_q[1] <= key[255:128];
		end else if (state_q == C_EXP) begin
			rk_q[step_q] <= next_grp;
		end
	end

endmodule

// ===== rtl/prf_back.sv =====
// ----------------------------------------------------------------------------
// prf_back
// Runs commands: restart, buffered bytes, counter blocks, and the result slot.
// ----------------------------------------------------------------------------
module prf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  prf_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	input  logic [31:0]        max_inv,
	output prf_pkg::aes_req_t  aes_req,
	output logic [63:0]        aes_ctr,
	input  prf_pkg::aes_resp_t aes_resp,
	input  logic [127:0]       aes_data,
	input  logic               pop,
	output logic               empty,
	output prf_pkg::res_t      res
);

	typedef enum logic [2:0] {B_IDLE, B_EXPAND, B_LOOP, B_ENC, B_EMIT} bstate_t;

	localparam logic [prf_pkg::CNT_W-1:0] BLK    = prf_pkg::CNT_W'(prf_pkg::BLOCK_BYTES);
	localparam logic [prf_pkg::LEN_W-1:0] BLK_L  = prf_pkg::LEN_W'(prf_pkg::BLOCK_BYTES);

	bstate_t                       state_q;
	bstate_t                       next_q;
	prf_pkg::res_t                 pend_q;
	prf_pkg::res_t                 out_q;
	logic                          out_valid_q;
	logic [63:0]                   counter_q;
	logic [31:0]                   remain_q;
	logic [prf_pkg::CNT_W-1:0]     bufpos_q;
	logic [127:0]                  buf_q;
	logic [prf_pkg::LEN_W-1:0]     rem_q;

	logic                          slot_free;
	logic [prf_pkg::LEN_W:0]       sum_w;
	logic [prf_pkg::CNT_W-1:0]     idx_w;
	logic [prf_pkg::LEN_W-1:0]     rem_w;
	logic [127:0]                  shifted_w;

	assign slot_free = !out_valid_q || pop;
	assign empty     = !out_valid_q;
	assign res       = out_q;
	assign cmd_pop   = (state_q == B_IDLE) && cmd_valid;
	assign aes_ctr   = counter_q;

	assign aes_req.expand  = cmd_pop && (cmd.kind == prf_pkg::CMD_RESTART) && (max_inv != '0);
	assign aes_req.encrypt = (state_q == B_LOOP) && (remain_q != '0);

	assign sum_w     = {1'b0, cmd.len} + (prf_pkg::LEN_W + 1)'(bufpos_q);
	assign idx_w     = BLK - bufpos_q;
	assign rem_w     = cmd.len - prf_pkg::LEN_W'(idx_w);
	assign shifted_w = buf_q >> {bufpos_q, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			next_q      <= B_IDLE;
			pend_q      <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			counter_q   <= '0;
			remain_q    <= '0;
			bufpos_q    <= BLK;
			buf_q       <= '0;
			rem_q       <= '0;
		end else begin
			// the emit state reloads the slot itself
			if (pop && out_valid_q && (state_q != B_EMIT)) out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						if (cmd.kind == prf_pkg::CMD_RESTART) begin
							if (max_inv == '0) begin
								pend_q  <= '{data: '0, cnt: '0, last: 1'b1,
								             status: prf_pkg::ST_NO_BUDGET};
								next_q  <= B_IDLE;
								state_q <= B_EMIT;
							end else begin
								counter_q <= '0;
								bufpos_q  <= BLK;
								remain_q  <= max_inv;
								state_q   <= B_EXPAND;
							end
						end else if (sum_w <= (prf_pkg::LEN_W + 1)'(prf_pkg::BLOCK_BYTES)) begin
							// whole request served from the buffer
							pend_q   <= '{data: prf_pkg::byte_mask(shifted_w, cmd.len[4:0]),
							              cnt: cmd.len[4:0], last: 1'b1,
							              status: prf_pkg::ST_OK};
							bufpos_q <= bufpos_q + cmd.len[4:0];
							next_q   <= B_IDLE;
							state_q  <= B_EMIT;
						end else begin
							bufpos_q <= '0;
							rem_q    <= rem_w;
							if (idx_w != '0) begin
								pend_q  <= '{data: prf_pkg::byte_mask(shifted_w, idx_w),
								             cnt: idx_w, last: 1'b0,
								             status: prf_pkg::ST_OK};
								next_q  <= B_LOOP;
								state_q <= B_EMIT;
							end else begin
								state_q <= B_LOOP;
							end
						end
					end
				end
				B_EXPAND: begin
					if (aes_resp.done) begin
						pend_q  <= '{data: '0, cnt: '0, last: 1'b1, status: prf_pkg::ST_OK};
						next_q  <= B_IDLE;
						state_q <= B_EMIT;
					end
				end
				B_LOOP: begin
					if (remain_q == '0) begin
						pend_q  <= '{data: '0, cnt: '0, last: 1'b1,
						             status: prf_pkg::ST_EXHAUSTED};
						next_q  <= B_IDLE;
						state_q <= B_EMIT;
					end else begin
						counter_q <= counter_q + 64'd1;
						remain_q  <= remain_q - 32'd1;
						state_q   <= B_ENC;
					end
				end
				B_ENC: begin
					if (aes_resp.done) begin
						if (rem_q < BLK_L) begin
							// refill the buffer and hand out its head when bytes remain
							buf_q    <= aes_data;
							bufpos_q <= rem_q[4:0];
							if (rem_q != '0) begin
								pend_q  <= '{data: prf_pkg::byte_mask(aes_data, rem_q[4:0]),
								             cnt: rem_q[4:0], last: 1'b1,
								             status: prf_pkg::ST_OK};
								next_q  <= B_IDLE;
								state_q <= B_EMIT;
							end else begin
								state_q <= B_IDLE;
							end
						end else begin
							// a full block is last only if the silent refill after it succeeds
							pend_q  <= '{data: aes_data, cnt: BLK,
							             last: (rem_q == BLK_L) && (remain_q != '0),
							             status: prf_pkg::ST_OK};
							rem_q   <= rem_q - BLK_L;
							next_q  <= B_LOOP;
							state_q <= B_EMIT;
						end
					end
				end
				B_EMIT: begin
					if (slot_free) begin
						out_q       <= pend_q;
						out_valid_q <= 1'b1;
						state_q     <= next_q;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/aes256_ctr_keystream_prf.sv =====
// ----------------------------------------------------------------------------
// aes256_ctr_keystream_prf
// AES-256 counter-mode pseudorandom byte generator with an APB register port.
// ----------------------------------------------------------------------------
// A restart runs the key schedule, one 128-bit group a cycle, thirteen
// groups. A generate request serves chunks from the buffer first and then
// encrypts fresh blocks in the iterative round unit, which does one AES
// round a cycle over fourteen rounds. Requests queue in a short command
// queue while the back end works, and a waiting result sits in an output
// register until popped. Chunks carry up to 16 bytes, first byte lowest,
// with unused bytes zero.
module aes256_ctr_keystream_prf #(
	parameter int MAX_REQUEST_BYTES = prf_pkg::MAX_REQ_BYTES_DEF,
	parameter int CMD_QUEUE_DEPTH   = prf_pkg::CMD_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [prf_pkg::ADDR_W-1:0]  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  logic                        opcode,
	input  logic [prf_pkg::LEN_W-1:0]   byte_length,
	output logic                        empty,
	input  logic                        pop,
	output logic [63:0]                 chunk_low,
	output logic [63:0]                 chunk_high,
	output logic [prf_pkg::CNT_W-1:0]   byte_count,
	output logic                        last,
	output logic [1:0]                  status
);

	logic [63:0]        key_q [4];
	logic [31:0]        max_inv_q;
	logic [2:0]         reg_idx;
	logic               cfg_wr;

	logic               q_full;
	logic               q_wr;
	prf_pkg::cmd_t      q_wcmd;
	prf_pkg::cmd_t      q_rcmd;
	logic               q_valid;
	logic               q_rd;

	prf_pkg::aes_req_t  aes_req;
	prf_pkg::aes_resp_t aes_resp;
	logic [63:0]        aes_ctr;
	logic [127:0]       aes_data;
	prf_pkg::res_t      res;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			max_inv_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				prf_pkg::REG_KEY0:    key_q[0]  <= pwdata;
				prf_pkg::REG_KEY1:    key_q[1]  <= pwdata;
				prf_pkg::REG_KEY2:    key_q[2]  <= pwdata;
				prf_pkg::REG_KEY3:    key_q[3]  <= pwdata;
				prf_pkg::REG_MAX_INV: max_inv_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			prf_pkg::REG_KEY0:    prdata = key_q[0];
			prf_pkg::REG_KEY1:    prdata = key_q[1];
			prf_pkg::REG_KEY2:    prdata = key_q[2];
			prf_pkg::REG_KEY3:    prdata = key_q[3];
			prf_pkg::REG_MAX_INV: prdata = {32'd0, max_inv_q};
			default:              prdata = '0;
		endcase
	end

	prf_front #(
		.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)
	) u_front (
		.push       (push),
		.opcode     (opcode),
		.byte_length(byte_length),
		.full       (full),
		.q_full     (q_full),
		.q_wr       (q_wr),
		.q_cmd      (q_wcmd)
	);

	prf_cmd_fifo #(
		.DEPTH(CMD_QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_wr),
		.wr_cmd(q_wcmd),
		.full  (q_full),
		.rd    (q_rd),
		.rd_cmd(q_rcmd),
		.valid (q_valid)
	);

	prf_aes_core u_aes (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (aes_req),
		.key   ({key_q[3], key_q[2], key_q[1], key_q[0]}),
		.ctr   (aes_ctr),
		.resp  (aes_resp),
		.data  (aes_data)
	);

	prf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd      (q_rcmd),
		.cmd_pop  (q_rd),
		.max_inv  (max_inv_q),
		.aes_req  (aes_req),
		.aes_ctr  (aes_ctr),
		.aes_resp (aes_resp),
		.aes_data (aes_data),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	assign chunk_low  = res.data[63:0];
	assign chunk_high = res.data[127:64];
	assign byte_count = res.cnt;
	assign last       = res.last;
	assign status     = res.status;

endmodule

// ===== rtl/prf_checker.sv =====
// ----------------------------------------------------------------------------
// prf_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prf_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      empty,
	input logic                      pop,
	input logic [63:0]               chunk_low,
	input logic [63:0]               chunk_high,
	input logic [prf_pkg::CNT_W-1:0] byte_count,
	input logic                      last,
	input logic [1:0]                status
);

	`PRF_ASSERT(a_count_range, clk, arst_n, empty || (byte_count <= 5'd16), "byte_count above 16")
	`PRF_ASSERT(a_error_ends, clk, arst_n, empty || (status == prf_pkg::ST_OK) || (last && (byte_count == '0)), "error result not a bare final")
	`PRF_ASSERT(a_empty_chunk, clk, arst_n, empty || (byte_count != '0) || ((chunk_low == '0) && (chunk_high == '0)), "empty chunk carries data")
	`PRF_ASSERT_HOLD(a_hold, clk, arst_n, !empty && !pop, {empty, chunk_low, chunk_high, byte_count, last, status}, "stalled result changed")

endmodule

bind aes256_ctr_keystream_prf prf_checker u_chk (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives restart and generate requests into the AES-256 CTR keystream
// generator through its queue ports, writes key and budget registers over
// APB between phases, and checks every chunk against a behavioral model of
// the key schedule, the cipher, the keystream buffer and the budget.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import prf_pkg::*;

	localparam int IDLE_PCT    = 18;
	localparam int WDOG_LIMIT  = 6000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_LEN     = 960;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  cnt;
		logic        lst;
		logic [1:0]  st;
	} chunk_t;

	typedef enum {ROW_REQ, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic      op;
		int        len;
		int        typed_st;   // -1: take the expected chunks from the model
		logic [2:0]  reg_idx;
		logic [63:0] reg_val;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [63:0]          pwdata = '0;
	logic [63:0]          prdata;
	logic                 pready;
	logic                 push = 1'b0;
	logic                 full;
	logic                 opcode = OP_GENERATE;
	logic [LEN_W-1:0]     byte_length = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [63:0]          chunk_low;
	logic [63:0]          chunk_high;
	logic [CNT_W-1:0]     byte_count;
	logic                 last;
	logic [1:0]           status;

	// model state
	logic [7:0]  sb [256];
	logic [63:0] key_reg [4];
	logic [31:0] budget_reg;
	logic [7:0]  sched [240];
	logic [63:0] blk_ctr;
	logic [31:0] budget_left;
	int          buf_pos;
	logic [7:0]  ks_buf [16];

	chunk_t chunk_q [$];
	int     errs = 0;
	bit     calm = 1'b0;
	bit     hold_req = 1'b0;
	bit     done = 1'b0;

	aes256_ctr_keystream_prf i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	// S-box from the field inverse (a^254) and the affine map
	function automatic void build_sbox();
		logic [7:0] inv;
		logic [7:0] sq;
		for (int a = 0; a < 256; a++) begin
			inv = 8'h01;
			sq  = 8'(a);
			for (int e = 0; e < 8; e++) begin
				if ((254 >> e) & 1) inv = gf_mul(inv, sq);
				sq = gf_mul(sq, sq);
			end
			sb[a] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
		end
	endfunction

	function automatic void expand_sched();
		logic [7:0] t [4];
		logic [7:0] x;
		int k;
		for (int i = 0; i < 32; i++) sched[i] = key_reg[i / 8][8 * (i % 8) +: 8];
		for (int i = 32; i < 240; i += 4) begin
			for (int j = 0; j < 4; j++) t[j] = sched[i - 4 + j];
			k = i / 4;
			if (k % 8 == 0) begin
				x = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = x;
				for (int j = 0; j < 4; j++) t[j] = sb[t[j]];
				t[0] ^= 8'h01 << ((k / 8) - 1);
			end else if (k % 8 == 4) begin
				for (int j = 0; j < 4; j++) t[j] = sb[t[j]];
			end
			for (int j = 0; j < 4; j++) sched[i + j] = sched[i - 32 + j] ^ t[j];
		end
	endfunction

	function automatic logic [7:0] dbl(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// encrypt the counter block and advance counter and budget
	function automatic void next_block(output logic [7:0] o [16]);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		for (int i = 0; i < 16; i++)
			s[i] = (i < 8 ? blk_ctr[8 * i +: 8] : 8'h00) ^ sched[i];
		for (int r = 1; r <= 14; r++) begin
			for (int i = 0; i < 16; i++) s[i] = sb[s[i]];
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++) t[c * 4 + i] = s[((c + i) % 4) * 4 + i];
			if (r != 14) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[c * 4]; a1 = t[c * 4 + 1]; a2 = t[c * 4 + 2]; a3 = t[c * 4 + 3];
					all = a0 ^ a1 ^ a2 ^ a3;
					t[c * 4]     = a0 ^ all ^ dbl(a0 ^ a1);
					t[c * 4 + 1] = a1 ^ all ^ dbl(a1 ^ a2);
					t[c * 4 + 2] = a2 ^ all ^ dbl(a2 ^ a3);
					t[c * 4 + 3] = a3 ^ all ^ dbl(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++) s[i] = t[i] ^ sched[r * 16 + i];
		end
		o = s;
		blk_ctr++;
		budget_left--;
	endfunction

	function automatic void add_chunk(input logic [7:0] b [16], input int off, input int cnt,
	                                  input logic [1:0] st);
		chunk_t c;
		c.lo = '0;
		c.hi = '0;
		for (int i = 0; i < cnt; i++) begin
			if (i < 8) c.lo[8 * i +: 8] = b[off + i];
			else c.hi[8 * (i - 8) +: 8] = b[off + i];
		end
		c.cnt = 5'(cnt);
		c.lst = 1'b0;
		c.st  = st;
		chunk_q.push_back(c);
	endfunction

	// queue the chunks that one request yields
	function automatic void predict_chunks(input logic op, input int req_len);
		logic [7:0] blk [16];
		int len, pos, idx, tail, n0;
		n0 = chunk_q.size();
		if (op == OP_RESTART) begin
			if (budget_reg == 0) begin
				add_chunk(ks_buf, 0, 0, ST_NO_BUDGET);
			end else begin
				expand_sched();
				blk_ctr     = '0;
				buf_pos     = BLOCK_BYTES;
				budget_left = budget_reg;
				add_chunk(ks_buf, 0, 0, ST_OK);
			end
		end else begin
			len = req_len > MAX_LEN ? MAX_LEN : req_len;
			pos = buf_pos;
			if (len + pos <= BLOCK_BYTES) begin
				add_chunk(ks_buf, pos % 16, len, ST_OK);
				buf_pos = pos + len;
			end else begin
				idx = BLOCK_BYTES - pos;
				if (idx > 0) add_chunk(ks_buf, pos, idx, ST_OK);
				buf_pos = 0;
				forever begin
					if (budget_left == 0) begin
						add_chunk(ks_buf, 0, 0, ST_EXHAUSTED);
						break;
					end
					next_block(blk);
					if (len - idx < BLOCK_BYTES) begin
						ks_buf  = blk;
						tail    = len - idx;
						buf_pos = tail;
						if (tail > 0 || chunk_q.size() == n0) add_chunk(blk, 0, tail, ST_OK);
						break;
					end
					add_chunk(blk, 0, BLOCK_BYTES, ST_OK);
					idx += BLOCK_BYTES;
				end
			end
		end
		chunk_q[$].lst = 1'b1;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		bit rdy;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 3'b000});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx < REG_MAX_INV) key_reg[idx] = val;
		else budget_reg = val[31:0];
		// leave the bus idle between transfers
		@(posedge clk);
	endtask

	// let the block drain before touching registers
	task automatic settle();
		wait (chunk_q.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_req(input logic op, input int len, input int typed_st);
		bit acc;
		chunk_t c;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push        <= 1'b1;
		opcode      <= op;
		byte_length <= LEN_W'(len);
		do begin
			@(negedge clk);
			acc = !full;
			@(posedge clk);
		end while (!acc);
		if (typed_st < 0) begin
			predict_chunks(op, len);
		end else begin
			// keep the model state in step, then replace its chunk with the typed one
			predict_chunks(op, len);
			void'(chunk_q.pop_back());
			c = '{lo: '0, hi: '0, cnt: '0, lst: 1'b1, st: 2'(typed_st)};
			chunk_q.push_back(c);
		end
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 55) return $urandom_range(40);
		if (r < 85) return $urandom_range(200);
		if (r < 95) return $urandom_range(600);
		return $urandom_range(1) ? 1023 : MAX_LEN;
	endfunction

	function automatic logic [63:0] pick_key();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [31:0] pick_budget();
		case ($urandom_range(5))
			0: return 32'($urandom_range(1, 4));
			1: return 32'hffff_ffff;
			2: return 32'($urandom_range(5, 40));
			default: return 32'($urandom_range(40, 400));
		endcase
	endfunction

	initial begin
		row_t tbl [$];
		row_t rw;
		bit   pushed;
		build_sbox();
		foreach (key_reg[i]) key_reg[i] = '0;
		budget_reg  = '0;
		blk_ctr     = '0;
		budget_left = '0;
		buf_pos     = BLOCK_BYTES;
		foreach (ks_buf[i]) ks_buf[i] = '0;
		foreach (sched[i]) sched[i] = '0;

		tbl = '{
			'{ROW_REQ, OP_RESTART,  0,    ST_NO_BUDGET, REG_KEY0, 64'h0},
			'{ROW_REQ, OP_GENERATE, 0,    ST_OK,        REG_KEY0, 64'h0},
			'{ROW_REQ, OP_GENERATE, 5,    ST_EXHAUSTED, REG_KEY0, 64'h0},
			'{ROW_REQ, OP_GENERATE, 3,    -1,           REG_KEY0, 64'h0},
			'{ROW_REG, OP_GENERATE, 0,    -1, REG_KEY0,    64'hffff_ffff_ffff_ffff},
			'{ROW_REG, OP_GENERATE, 0,    -1, REG_KEY1,    64'hffff_ffff_ffff_ffff},
			'{ROW_REG, OP_GENERATE, 0,    -1, REG_KEY2,    64'hffff_ffff_ffff_ffff},
			'{ROW_REG, OP_GENERATE, 0,    -1, REG_KEY3,    64'hffff_ffff_ffff_ffff},
			'{ROW_REG, OP_GENERATE, 0,    -1, REG_MAX_INV, 64'd3},
			'{ROW_REQ, OP_RESTART,  0,    ST_OK,        REG_KEY0, 64'h0},
			'{ROW_REQ, OP_GENERATE, 1023, -1,           REG_KEY0, 64'h0},
			'{ROW_REQ, OP_GENERATE, 0,    ST_OK,        REG_KEY0, 64'h0},
			'{ROW_REG, OP_GENERATE, 0,    -1, REG_KEY0,    64'h0},
			'{ROW_REG, OP_GENERATE, 0,    -1, REG_KEY1,    64'h0},
			'{ROW_REG, OP_GENERATE, 0,    -1, REG_KEY2,    64'h0},
			'{ROW_REG, OP_GENERATE, 0,    -1, REG_KEY3,    64'h0},
			'{ROW_REG, OP_GENERATE, 0,    -1, REG_MAX_INV, 64'hffff_ffff},
			'{ROW_REQ, OP_RESTART,  0,    ST_OK,        REG_KEY0, 64'h0},
			'{ROW_REQ, OP_GENERATE, 16,   -1,           REG_KEY0, 64'h0},
			'{ROW_REQ, OP_GENERATE, 1,    -1,           REG_KEY0, 64'h0},
			'{ROW_REQ, OP_GENERATE, 15,   -1,           REG_KEY0, 64'h0},
			'{ROW_REQ, OP_GENERATE, 17,   -1,           REG_KEY0, 64'h0},
			'{ROW_REQ, OP_GENERATE, 32,   -1,           REG_KEY0, 64'h0},
			'{ROW_REQ, OP_GENERATE, 960,  -1,           REG_KEY0, 64'h0},
			'{ROW_REQ, OP_GENERATE, 7,    -1,           REG_KEY0, 64'h0},
			'{ROW_REQ, OP_GENERATE, 512,  -1,           REG_KEY0, 64'h0},
			'{ROW_REQ, OP_RESTART,  0,    ST_OK,        REG_KEY0, 64'h0},
			'{ROW_REQ, OP_GENERATE, 0,    ST_OK,        REG_KEY0, 64'h0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pushed = 1'b0;
		foreach (tbl[i]) begin
			rw = tbl[i];
			if (rw.kind == ROW_REG) begin
				if (pushed) begin
					push <= 1'b0;
					settle();
					pushed = 1'b0;
				end
				write_reg(rw.reg_idx, rw.reg_val);
			end else begin
				send_req(rw.op, rw.len, rw.typed_st);
				pushed = 1'b1;
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			// hold new requests until the block has drained
			push <= 1'b0;
			settle();
			calm = (ph == 3);
			for (int k = 0; k < 4; k++) write_reg(3'(k), pick_key());
			write_reg(REG_MAX_INV, ph == 4 ? 64'h0 : 64'(pick_budget()));
			send_req(OP_RESTART, 0, -1);
			if (ph == 2) hold_req = 1'b1;
			for (int k = 0; k < 50; k++) begin
				if ($urandom_range(99) < 8) send_req(OP_RESTART, $urandom_range(1023), -1);
				else send_req(OP_GENERATE, pick_len(), -1);
			end
		end
		push <= 1'b0;
		calm = 1'b0;
		wait (chunk_q.size() == 0);
		repeat (100) @(posedge clk);
		if (errs == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

	// result side: random pop, with one long hold-off on request
	initial begin
		chunk_t e;
		forever begin
			@(negedge clk);
			if (pop && !empty) begin
				if (chunk_q.size() == 0) begin
					$error("unexpected chunk: low %h high %h count %0d", chunk_low,
						chunk_high, byte_count);
					errs++;
				end else begin
					e = chunk_q.pop_front();
					if (chunk_low !== e.lo) begin
						$error("chunk_low: expected %h, got %h", e.lo, chunk_low);
						errs++;
					end
					if (chunk_high !== e.hi) begin
						$error("chunk_high: expected %h, got %h", e.hi, chunk_high);
						errs++;
					end
					if (byte_count !== e.cnt) begin
						$error("byte_count: expected %0d, got %0d", e.cnt, byte_count);
						errs++;
					end
					if (last !== e.lst) begin
						$error("last: expected %0d, got %0d", e.lst, last);
						errs++;
					end
					if (status !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, status);
						errs++;
					end
				end
			end
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pop <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(negedge clk);
			if ((push && !full) || (pop && !empty) || psel || !arst_n) quiet = 0;
			else quiet++;
			if (quiet >= WDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/prf_pkg.sv
rtl/prf_front.sv
rtl/prf_cmd_fifo.sv
rtl/prf_aes_core.sv
rtl/prf_back.sv
rtl/aes256_ctr_keystream_prf.sv
rtl/prf_checker.sv
tb/testbench.sv
